>>> rtl/ilx_pkg.sv
// Shared types, character codes and digit decode for the integer literal lexer.
// No dependencies.
package ilx_pkg;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;

   localparam logic [1:0] RK_DEC = 2'd0;
   localparam logic [1:0] RK_OCT = 2'd1;
   localparam logic [1:0] RK_HEX = 2'd2;
   localparam logic [1:0] RK_BIN = 2'd3;

   typedef struct packed {
      logic        is_number;
      logic [31:0] literal_value;
      logic [7:0]  literal_length;
      logic [1:0]  radix_kind;
      logic [1:0]  pushback;
   } result_type;

   // {ok, value}: ok is set when c is a digit of the radix named by rk
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] rk);
      logic       ok;
      logic [3:0] d;
      ok = 1'b0;
      d  = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         ok = 1'b1;
         d  = c[3:0];
      end else if ((c >= CHAR_LOW_A && c <= CHAR_LOW_F) ||
                   (c >= CHAR_UP_A && c <= CHAR_UP_F)) begin
         ok = 1'b1;
         d  = c[3:0] + 4'd9;
      end
      case (rk)
         RK_DEC:  ok = ok && (d < 4'd10);
         RK_OCT:  ok = ok && (d < 4'd8);
         RK_BIN:  ok = ok && (d < 4'd2);
         default: ok = ok;
      endcase
      return {ok, d};
   endfunction

endpackage

>>> rtl/integer_literal_lexer.sv
// Top level of the integer literal lexer: input register, scanner, result register.
// Depends on ilx_pkg and ilx_scan.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_character
//   rsp      out        rsp_valid / rsp_stall  rsp_is_number .. rsp_pushback
//
// One character per cycle sustained while rsp is not stalled; the character that ends the
// literal passes the input register, then its result is captured in the result register.
// The scanner's one-step update of mode, accumulator and length sets the rate.
// Reset clears the scanner to idle and empties both registers.
// A stalled result holds the scanner and, once the input register is full, req.
module integer_literal_lexer #(
   parameter int LENGTH_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_number,
   output logic [31:0] rsp_literal_value,
   output logic [7:0]  rsp_literal_length,
   output logic [1:0]  rsp_radix_kind,
   output logic [1:0]  rsp_pushback
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          chr_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   ilx_pkg::result_type rsp_ff;
   ilx_pkg::result_type scan_res;
   logic                scan_res_valid;
   logic                advance, take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   ilx_scan #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .chr       (chr_ff),
      .res_valid (scan_res_valid),
      .res       (scan_res)
   );

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && scan_res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         chr_ff <= req_character;
      end
      if (advance && scan_res_valid) begin
         rsp_ff <= scan_res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_number      = rsp_ff.is_number;
   assign rsp_literal_value  = rsp_ff.literal_value;
   assign rsp_literal_length = rsp_ff.literal_length;
   assign rsp_radix_kind     = rsp_ff.radix_kind;
   assign rsp_pushback       = rsp_ff.pushback;

endmodule

>>> rtl/ilx_scan.sv
// Literal scanner: mode, accumulator, length and prefix registers with next-state logic.
// Depends on ilx_pkg.
module ilx_scan #(
   parameter int LENGTH_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             chr,
   output logic                   res_valid,
   output ilx_pkg::result_type    res
);

   localparam logic [2:0] M_IDLE   = 3'd0;
   localparam logic [2:0] M_ZERO   = 3'd1;
   localparam logic [2:0] M_PREFIX = 3'd2;
   localparam logic [2:0] M_DEC    = 3'd3;
   localparam logic [2:0] M_OCT    = 3'd4;
   localparam logic [2:0] M_HEX    = 3'd5;
   localparam logic [2:0] M_BIN    = 3'd6;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   logic [2:0]             mode_ff, mode_in;
   logic [31:0]            acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in, len_inc1, len_inc2;
   logic                   prefix_ff, prefix_in;
   logic [7:0]             len_out;
   logic [1:0]             run_rk, pre_rk;
   logic [4:0]             dig_run, dig_oct, dig_pre;
   logic [31:0]            acc_scaled;

   if (LENGTH_BITS >= 8) begin : g_len_wide
      assign len_out = len_ff[7:0];
   end else begin : g_len_narrow
      assign len_out = {{(8-LENGTH_BITS){1'b0}}, len_ff};
   end

   assign len_inc1 = (len_ff == LEN_MAX) ? LEN_MAX : len_ff + LEN_ONE;
   assign len_inc2 = (len_inc1 == LEN_MAX) ? LEN_MAX : len_inc1 + LEN_ONE;

   always_comb begin
      case (mode_ff)
         M_DEC:   run_rk = ilx_pkg::RK_DEC;
         M_OCT:   run_rk = ilx_pkg::RK_OCT;
         M_HEX:   run_rk = ilx_pkg::RK_HEX;
         default: run_rk = ilx_pkg::RK_BIN;
      endcase
   end

   assign pre_rk  = prefix_ff ? ilx_pkg::RK_BIN : ilx_pkg::RK_HEX;
   assign dig_run = ilx_pkg::digit_of(chr, run_rk);
   assign dig_oct = ilx_pkg::digit_of(chr, ilx_pkg::RK_OCT);
   assign dig_pre = ilx_pkg::digit_of(chr, pre_rk);

   // constant multiply by the radix as shifts, with an add of two shifts for decimal
   always_comb begin
      case (run_rk)
         ilx_pkg::RK_DEC: acc_scaled = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0};
         ilx_pkg::RK_OCT: acc_scaled = {acc_ff[28:0], 3'b000};
         ilx_pkg::RK_HEX: acc_scaled = {acc_ff[27:0], 4'b0000};
         default:         acc_scaled = {acc_ff[30:0], 1'b0};
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      res_valid = 1'b0;
      res.is_number      = 1'b1;
      res.literal_value  = 32'd0;
      res.literal_length = len_out;
      res.radix_kind     = ilx_pkg::RK_OCT;
      res.pushback       = 2'd1;
      case (mode_ff)
         M_ZERO: begin
            if (chr == ilx_pkg::CHAR_X || chr == ilx_pkg::CHAR_B) begin
               prefix_in = (chr == ilx_pkg::CHAR_B);
               mode_in   = M_PREFIX;
            end else if (dig_oct[4]) begin
               acc_in  = {28'd0, dig_oct[3:0]};
               len_in  = len_inc1;
               mode_in = M_OCT;
            end else begin
               res_valid = 1'b1;
            end
         end
         M_PREFIX: begin
            if (dig_pre[4]) begin
               acc_in  = {28'd0, dig_pre[3:0]};
               len_in  = len_inc2;
               mode_in = prefix_ff ? M_BIN : M_HEX;
            end else begin
               // push the prefix letter and this character back to the next token
               res_valid    = 1'b1;
               res.pushback = 2'd2;
            end
         end
         M_DEC, M_OCT, M_HEX, M_BIN: begin
            if (dig_run[4]) begin
               acc_in = acc_scaled + {28'd0, dig_run[3:0]};
               len_in = len_inc1;
            end else begin
               res_valid         = 1'b1;
               res.literal_value = acc_ff;
               res.radix_kind    = run_rk;
            end
         end
         default: begin
            acc_in    = 32'd0;
            prefix_in = 1'b0;
            if (chr == ilx_pkg::CHAR_ZERO) begin
               mode_in = M_ZERO;
               len_in  = LEN_ONE;
            end else if (chr >= ilx_pkg::CHAR_ONE && chr <= ilx_pkg::CHAR_NINE) begin
               mode_in = M_DEC;
               acc_in  = {28'd0, chr[3:0]};
               len_in  = LEN_ONE;
            end else begin
               mode_in            = M_IDLE;
               len_in             = '0;
               res_valid          = 1'b1;
               res.is_number      = 1'b0;
               res.literal_length = 8'd0;
               res.radix_kind     = ilx_pkg::RK_DEC;
            end
         end
      endcase
      if (res_valid) begin
         mode_in   = M_IDLE;
         acc_in    = 32'd0;
         len_in    = '0;
         prefix_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         acc_ff    <= 32'd0;
         len_ff    <= '0;
         prefix_ff <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

>>> test/integer_literal_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_literal_lexer: feeds character streams and
// compares every token against an in-bench scanner model. Depends on ilx_pkg.
module integer_literal_lexer_tb;

   localparam int         CYCLE_LIMIT   = 300000;
   localparam int         RANDOM_CHARS  = 390;
   localparam logic [7:0] LENGTH_MAX    = 8'hFF;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_ZERO   = 3'd1;
   localparam logic [2:0] MODE_PREFIX = 3'd2;
   localparam logic [2:0] MODE_DEC    = 3'd3;
   localparam logic [2:0] MODE_OCT    = 3'd4;
   localparam logic [2:0] MODE_HEX    = 3'd5;
   localparam logic [2:0] MODE_BIN    = 3'd6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_number;
   logic [31:0] rsp_literal_value;
   logic [7:0]  rsp_literal_length;
   logic [1:0]  rsp_radix_kind;
   logic [1:0]  rsp_pushback;

   // scanner model state
   logic [2:0]  scan_mode = MODE_IDLE;
   logic [31:0] scan_value = '0;
   logic [7:0]  scan_length = '0;
   logic        scan_prefix_b = 1'b0;

   ilx_pkg::result_type expected_tokens[$];
   int          error_count = 0;
   int          tokens_seen = 0;
   int          chars_sent = 0;
   int          cycle_count = 0;
   int          rx_wait = 0;
   int          rx_hold = 0;
   int          rx_next;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b0;

   integer_literal_lexer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_number      (rsp_is_number),
      .rsp_literal_value  (rsp_literal_value),
      .rsp_literal_length (rsp_literal_length),
      .rsp_radix_kind     (rsp_radix_kind),
      .rsp_pushback       (rsp_pushback)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("integer_literal_lexer_tb: done, errors");
         $finish;
      end
   end

   // digit value of ch in the given radix, -1 when ch is no digit of it
   function automatic int digit_value(input logic [7:0] ch, input int radix);
      int v;
      v = -1;
      if (ch >= ilx_pkg::CHAR_ZERO && ch <= ilx_pkg::CHAR_NINE)
         v = int'(ch - ilx_pkg::CHAR_ZERO);
      else if (ch >= ilx_pkg::CHAR_LOW_A && ch <= ilx_pkg::CHAR_LOW_F)
         v = int'(ch - ilx_pkg::CHAR_LOW_A) + 10;
      else if (ch >= ilx_pkg::CHAR_UP_A && ch <= ilx_pkg::CHAR_UP_F)
         v = int'(ch - ilx_pkg::CHAR_UP_A) + 10;
      if (v >= radix) v = -1;
      return v;
   endfunction

   function automatic logic [7:0] length_inc(input logic [7:0] n);
      return (n == LENGTH_MAX) ? LENGTH_MAX : n + 8'd1;
   endfunction

   function automatic ilx_pkg::result_type make_token(input logic is_num,
                                                      input logic [31:0] value,
                                                      input logic [7:0] len,
                                                      input logic [1:0] rk,
                                                      input logic [1:0] pb);
      ilx_pkg::result_type t;
      t.is_number      = is_num;
      t.literal_value  = value;
      t.literal_length = len;
      t.radix_kind     = rk;
      t.pushback       = pb;
      return t;
   endfunction

   task automatic scan_clear();
      scan_mode     = MODE_IDLE;
      scan_value    = '0;
      scan_length   = '0;
      scan_prefix_b = 1'b0;
   endtask

   // advance the scanner model by one accepted character
   task automatic predict_char(input logic [7:0] ch);
      int         d;
      int         radix;
      logic [1:0] rk;
      case (scan_mode)
         MODE_ZERO: begin
            if (ch == ilx_pkg::CHAR_X || ch == ilx_pkg::CHAR_B) begin
               scan_prefix_b = (ch == ilx_pkg::CHAR_B);
               scan_mode     = MODE_PREFIX;
            end else begin
               d = digit_value(ch, 8);
               if (d >= 0) begin
                  scan_value  = 32'(d);
                  scan_length = length_inc(scan_length);
                  scan_mode   = MODE_OCT;
               end else begin
                  expected_tokens.push_back(
                     make_token(1'b1, '0, scan_length, ilx_pkg::RK_OCT, 2'd1));
                  scan_clear();
               end
            end
         end
         MODE_PREFIX: begin
            d = digit_value(ch, scan_prefix_b ? 2 : 16);
            if (d >= 0) begin
               scan_value  = 32'(d);
               scan_length = length_inc(length_inc(scan_length));
               scan_mode   = scan_prefix_b ? MODE_BIN : MODE_HEX;
            end else begin
               // the prefix letter and this character both go back
               expected_tokens.push_back(
                  make_token(1'b1, '0, scan_length, ilx_pkg::RK_OCT, 2'd2));
               scan_clear();
            end
         end
         MODE_DEC, MODE_OCT, MODE_HEX, MODE_BIN: begin
            case (scan_mode)
               MODE_DEC: begin radix = 10; rk = ilx_pkg::RK_DEC; end
               MODE_OCT: begin radix = 8;  rk = ilx_pkg::RK_OCT; end
               MODE_HEX: begin radix = 16; rk = ilx_pkg::RK_HEX; end
               default:  begin radix = 2;  rk = ilx_pkg::RK_BIN; end
            endcase
            d = digit_value(ch, radix);
            if (d >= 0) begin
               scan_value  = scan_value * 32'(radix) + 32'(d);
               scan_length = length_inc(scan_length);
            end else begin
               expected_tokens.push_back(
                  make_token(1'b1, scan_value, scan_length, rk, 2'd1));
               scan_clear();
            end
         end
         default: begin
            scan_clear();
            if (ch == ilx_pkg::CHAR_ZERO) begin
               scan_mode   = MODE_ZERO;
               scan_length = 8'd1;
            end else if (ch >= ilx_pkg::CHAR_ONE && ch <= ilx_pkg::CHAR_NINE) begin
               scan_mode   = MODE_DEC;
               scan_value  = 32'(ch - ilx_pkg::CHAR_ZERO);
               scan_length = 8'd1;
            end else begin
               expected_tokens.push_back(
                  make_token(1'b0, '0, '0, ilx_pkg::RK_DEC, 2'd1));
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in token %0d, %s: got %0h, want %0h", tokens_seen, what, got, want);
      error_count++;
   endtask

   // send one character; valid stays high when the next item follows at once
   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_char(ch);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // drop valid and hold until every expected token has arrived
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stall before each token, plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait   <= 0;
      end else begin
         rx_next = rx_wait;
         if (rsp_valid && !rsp_stall) rx_next = rx_calm ? 0 : $urandom_range(0, 5);
         if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            rsp_stall <= 1'b1;
         end else if (rx_next > 0) begin
            rsp_stall <= 1'b1;
            rx_next   = rx_next - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
         rx_wait <= rx_next;
      end
   end

   always @(posedge clock) begin
      ilx_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token", rsp_literal_value, '0);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_is_number !== want.is_number)
               report_mismatch("is_number", rsp_is_number, want.is_number);
            if (rsp_literal_value !== want.literal_value)
               report_mismatch("literal_value", rsp_literal_value, want.literal_value);
            if (rsp_literal_length !== want.literal_length)
               report_mismatch("literal_length", rsp_literal_length, want.literal_length);
            if (rsp_radix_kind !== want.radix_kind)
               report_mismatch("radix_kind", rsp_radix_kind, want.radix_kind);
            if (rsp_pushback !== want.pushback)
               report_mismatch("pushback", rsp_pushback, want.pushback);
         end
         tokens_seen++;
      end
   end

   task automatic test_directed();
      send_char(8'h00);
      send_char(8'hFF);
      send_text("0 ");       // lone zero
      send_text("0xg");      // hex prefix without digit
      send_text("0b2");      // binary prefix without digit
      send_text("0xFa ");    // mixed-case hex digits
      send_text("017 ");
      send_text("0X");       // uppercase X is no prefix
      send_text("0b10 ");
      wait_drain();
   endtask

   // length saturates, value keeps wrapping
   task automatic test_long_literals();
      int v;
      send_char(ilx_pkg::CHAR_ONE);
      repeat (259) send_char(ilx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      send_char(CHAR_SPACE);
      send_text("0x");
      repeat (254) begin
         v = $urandom_range(0, 15);
         send_char(v < 10 ? ilx_pkg::CHAR_ZERO + 8'(v) : ilx_pkg::CHAR_UP_A + 8'(v - 10));
      end
      send_char(8'($urandom_range(0, 255)));
      wait_drain();
   endtask

   task automatic test_random_text();
      int start;
      int kind;
      int v;
      int tokens;
      start  = chars_sent;
      tokens = 0;
      while (chars_sent < start + RANDOM_CHARS) begin
         if (tokens % 25 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
         end
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1: begin
               send_char(ilx_pkg::CHAR_ONE + 8'($urandom_range(0, 8)));
               repeat ($urandom_range(0, 11))
                  send_char(ilx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            2: begin
               send_char(ilx_pkg::CHAR_ZERO);
               repeat ($urandom_range(1, 12))
                  send_char(ilx_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
            end
            3, 4: begin
               send_text("0x");
               repeat ($urandom_range(1, 10)) begin
                  v = $urandom_range(0, 15);
                  if (v < 10) send_char(ilx_pkg::CHAR_ZERO + 8'(v));
                  else send_char(($urandom_range(0, 1) ? ilx_pkg::CHAR_LOW_A : ilx_pkg::CHAR_UP_A)
                                 + 8'(v - 10));
               end
            end
            5: begin
               send_text("0b");
               repeat ($urandom_range(1, 34))
                  send_char(ilx_pkg::CHAR_ZERO + 8'($urandom_range(0, 1)));
            end
            6: send_char(ilx_pkg::CHAR_ZERO);
            7: begin
               send_char(ilx_pkg::CHAR_ZERO);
               send_char($urandom_range(0, 1) ? ilx_pkg::CHAR_X : ilx_pkg::CHAR_B);
            end
            default: repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
         endcase
         // terminator: sometimes a separator, mostly any byte
         if ($urandom_range(0, 2) == 0) send_char(CHAR_SPACE);
         else send_char(8'($urandom_range(0, 255)));
         tokens++;
      end
      wait_drain();
      tx_calm = 1'b0;
      rx_calm <= 1'b0;
   endtask

   // hold the receiver off while the sender keeps offering items
   task automatic test_backpressure();
      wait_drain();
      tx_calm = 1'b1;
      rx_hold <= 80;
      repeat (20) begin
         send_char(8'($urandom_range(8'h3a, 8'h60)));
         send_text("0x7f;");
      end
      tx_calm = 1'b0;
      wait_drain();
   endtask

   // pause the sender after each burst until all tokens are back
   task automatic test_drain_pause();
      repeat (4) begin
         send_text("42,0b1,0777 ");
         wait_drain();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_literals();
      test_random_text();
      test_backpressure();
      test_drain_pause();
      wait_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("integer_literal_lexer_tb: done, clean");
      end else begin
         $display("integer_literal_lexer_tb: done, errors");
      end
      $finish;
   end

endmodule
